[rtl/core/ax25_frame_bit_transmitter_assert.svh]
// Assertion macros shared by the checker of the frame bit transmitter.
`ifndef AX25_FRAME_BIT_TRANSMITTER_ASSERT_SVH
`define AX25_FRAME_BIT_TRANSMITTER_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define AX25_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("ax25 transmitter assertion failed");

// Condition implies consequence in the next cycle.
`define AX25_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("ax25 transmitter assertion failed");

`endif

[rtl/core/afbt_pkg.sv]
package afbt_pkg;

  localparam int QueueDepth = 2;

  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_FLAG    = 2'd1;
  localparam logic [1:0] OP_PAYLOAD = 2'd2;
  localparam logic [1:0] OP_FCS     = 2'd3;

  localparam logic [15:0] FCS_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h8408;

  localparam logic [2:0] ONES_MAX   = 3'd7;
  localparam logic [2:0] ONES_STUFF = 3'd5;

  localparam logic [4:0] BYTE_BITS = 5'd8;
  localparam logic [4:0] FCS_BITS  = 5'd16;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
  } in_word_t;

  typedef struct packed {
    logic level;
    logic last;
  } out_word_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] bits;
  } cmd_t;

endpackage

[rtl/core/afbt_front.sv]
module afbt_front
  import afbt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_word_t in_word,
  input  logic     q_full,
  output logic     q_push,
  output cmd_t     q_cmd
);

  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  logic [15:0] fcs_r;
  logic [15:0] fcs_nxt;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    fcs_nxt    = fcs_r;
    q_cmd.op   = in_word.op;
    q_cmd.bits = {8'h00, in_word.data};
    case (in_word.op)
      OP_START: begin
        fcs_nxt = FCS_INIT;
      end
      OP_PAYLOAD: begin
        fcs_nxt = crc_fold(fcs_r, in_word.data);
      end
      OP_FCS: begin
        q_cmd.bits = ~fcs_r;
      end
      default: begin
        fcs_nxt = fcs_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fcs_r <= FCS_INIT;
    end else if (q_push) begin
      fcs_r <= fcs_nxt;
    end
  end

endmodule

[rtl/core/afbt_fifo.sv]
module afbt_fifo
  import afbt_pkg::*;
#(
  parameter int QDepth = QueueDepth
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t pop_cmd
);

  localparam int AW = (QDepth > 1) ? $clog2(QDepth) : 1;

  cmd_t        mem_r [QDepth];
  logic [AW:0] wptr_r;
  logic [AW:0] rptr_r;
  logic [AW:0] wptr_nxt;
  logic [AW:0] rptr_nxt;

  assign full    = (wptr_r[AW] != rptr_r[AW]) && (wptr_r[AW-1:0] == rptr_r[AW-1:0]);
  assign valid   = (wptr_r != rptr_r);
  assign pop_cmd = mem_r[rptr_r[AW-1:0]];

  assign wptr_nxt = (wptr_r[AW-1:0] == AW'(QDepth - 1)) ?
                    {~wptr_r[AW], {AW{1'b0}}} : wptr_r + 1'b1;
  assign rptr_nxt = (rptr_r[AW-1:0] == AW'(QDepth - 1)) ?
                    {~rptr_r[AW], {AW{1'b0}}} : rptr_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
    end else begin
      if (push && !full) begin
        wptr_r <= wptr_nxt;
      end
      if (pop && valid) begin
        rptr_r <= rptr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wptr_r[AW-1:0]] <= push_cmd;
    end
  end

endmodule

[rtl/core/afbt_back.sv]
module afbt_back
  import afbt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  cmd_t      q_cmd,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic        busy_r, busy_nxt;
  logic [1:0]  op_r, op_nxt;
  logic [15:0] shreg_r, shreg_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        stuff_r, stuff_nxt;
  logic        fin_r, fin_nxt;
  logic [2:0]  ones_r, ones_nxt;
  logic        level_r, level_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_word_t   out_word_r, out_word_nxt;

  logic        can_emit;
  logic        emit;
  logic        done;
  logic        last_bit;
  logic        stuffing;
  logic [2:0]  ones_inc;
  out_word_t   emit_word;

  assign can_emit  = !out_valid_r || !out_stall;
  assign stuffing  = (op_r == OP_PAYLOAD) || (op_r == OP_FCS);
  assign last_bit  = (cnt_r == 5'd1);
  assign ones_inc  = (ones_r == ONES_MAX) ? ONES_MAX : ones_r + 3'd1;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    busy_nxt  = busy_r;
    op_nxt    = op_r;
    shreg_nxt = shreg_r;
    cnt_nxt   = cnt_r;
    stuff_nxt = stuff_r;
    fin_nxt   = fin_r;
    ones_nxt  = ones_r;
    level_nxt = level_r;
    emit      = 1'b0;
    done      = 1'b0;
    emit_word = '0;

    if (busy_r && can_emit) begin
      emit = 1'b1;
      if (op_r == OP_START) begin
        level_nxt = 1'b1;
        ones_nxt  = '0;
        emit_word = '{level: 1'b1, last: 1'b1};
        done      = 1'b1;
      end else if (stuff_r) begin
        level_nxt = ~level_r;
        ones_nxt  = '0;
        stuff_nxt = 1'b0;
        emit_word = '{level: ~level_r, last: fin_r};
        done      = fin_r;
      end else begin
        shreg_nxt = shreg_r >> 1;
        cnt_nxt   = cnt_r - 5'd1;
        if (!shreg_r[0]) begin
          ones_nxt  = '0;
          level_nxt = ~level_r;
          emit_word = '{level: ~level_r, last: last_bit};
          done      = last_bit;
        end else begin
          ones_nxt = ones_inc;
          if (stuffing && (ones_inc == ONES_STUFF)) begin
            emit_word = '{level: level_r, last: 1'b0};
            stuff_nxt = 1'b1;
            fin_nxt   = last_bit;
          end else begin
            emit_word = '{level: level_r, last: last_bit};
            done      = last_bit;
          end
        end
      end
    end

    q_pop = q_valid && (!busy_r || done);

    if (done) begin
      busy_nxt = 1'b0;
    end
    if (q_pop) begin
      busy_nxt  = 1'b1;
      op_nxt    = q_cmd.op;
      shreg_nxt = q_cmd.bits;
      cnt_nxt   = (q_cmd.op == OP_FCS) ? FCS_BITS : BYTE_BITS;
      stuff_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = emit_word;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      stuff_r     <= 1'b0;
      fin_r       <= 1'b0;
      ones_r      <= '0;
      level_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      cnt_r       <= cnt_nxt;
      stuff_r     <= stuff_nxt;
      fin_r       <= fin_nxt;
      ones_r      <= ones_nxt;
      level_r     <= level_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    shreg_r    <= shreg_nxt;
    out_word_r <= out_word_nxt;
  end

endmodule

[rtl/core/ax25_frame_bit_transmitter.sv]
// Frame bit transmitter: turns frame words into NRZI line levels, one per bit time.
// Input channel (in_valid, in_stall, in_word): each word carries an op and a data
// byte. Op start resets the CRC, stuff counter and line level and yields one level;
// op flag sends a byte without stuffing; op payload sends a stuffed byte and folds
// it into the CRC; op fcs sends the complemented CRC, low byte first, stuffed.
// Output channel (out_valid, out_stall, out_word): one word per line bit, with
// last set on the final bit that an input word produces.
// An input word is classified in the front stage and written to a small queue in
// the accept cycle; the serializer takes it from the queue into its state registers,
// and from them its first line bit goes to the output register.
// The serializer sets the rate: it emits one line bit per cycle unless the output
// stalls, and a word yields 1 line bit (start), 8 to 10 (byte) or 16 to 20 (fcs).
// in_stall rises only when the queue is full.
// A stalled output holds its word and the serializer pauses with it.
// Reset (synchronous, active low) empties the queue, sets the CRC to all ones,
// clears the ones counter and sets the serializer's line level high.
module ax25_frame_bit_transmitter
  import afbt_pkg::*;
#(
  parameter int QDepth = QueueDepth
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic q_full;
  logic q_push;
  cmd_t q_push_cmd;
  logic q_pop;
  logic q_valid;
  cmd_t q_pop_cmd;

  afbt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_push_cmd)
  );

  afbt_fifo #(
    .QDepth (QDepth)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_cmd  (q_pop_cmd)
  );

  afbt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_pop_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

[rtl/core/afbt_checker.sv]
`include "ax25_frame_bit_transmitter_assert.svh"

module afbt_checker
  import afbt_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);

  logic [4:0] run_r;
  logic [4:0] run_nxt;
  logic       out_take;

  assign out_take = out_valid && !out_stall;

  always_comb begin
    run_nxt = run_r;
    if (out_take) begin
      run_nxt = out_word.last ? 5'd0 : run_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0;
    end else begin
      run_r <= run_nxt;
    end
  end

  // No input word can produce more than twenty line bits.
  `AX25_ASSERT_NOW(a_run_bounded, clk, rst_n, out_take && !out_word.last, run_r < 5'd19)
  `AX25_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                    out_valid && $stable(out_word))
  `AX25_ASSERT_NOW(a_quiet_after_reset, clk, 1'b1, $rose(rst_n), !out_valid && !in_stall)
  `AX25_ASSERT_NEXT(a_no_stall_after_idle, clk, rst_n, !in_valid && !out_valid && !in_stall,
                    !in_stall)

endmodule

bind ax25_frame_bit_transmitter afbt_checker u_afbt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

[test/ax25_frame_bit_transmitter_test.sv]
`timescale 1ns / 1ps

module ax25_frame_bit_transmitter_test;
  import afbt_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int CalmItems = 40;

  typedef struct {
    in_word_t w;
    bit settle;
  } stim_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;

  stim_t pending_q[$];
  out_word_t line_bits_q[$];

  logic [15:0] frame_crc = FCS_INIT;
  logic [2:0] ones_run_cnt = '0;
  logic nrzi_level = 1'b1;

  int accepted = 0;
  int total = 0;
  int err_cnt = 0;
  int cycle_cnt = 0;
  int gap_cnt = 0;
  int stall_cnt = 0;
  logic quiet = 1'b0;
  stim_t nxt;
  out_word_t want;

  ax25_frame_bit_transmitter uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word(out_word)
  );

  always #4 clk = ~clk;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // Works out the line levels that one accepted word produces and queues them.
  task automatic serialize_word(input in_word_t w);
    logic [15:0] bits;
    int nbits;
    bit stuffing;
    bit lv_q[$];
    out_word_t ow;
    bits = '0;
    nbits = 0;
    stuffing = 1'b0;
    case (w.op)
      OP_START: begin
        frame_crc = FCS_INIT;
        ones_run_cnt = '0;
        nrzi_level = 1'b1;
        lv_q.push_back(nrzi_level);
      end
      OP_FLAG: begin
        bits = {8'h00, w.data};
        nbits = 8;
      end
      OP_PAYLOAD: begin
        frame_crc = crc_byte(frame_crc, w.data);
        bits = {8'h00, w.data};
        nbits = 8;
        stuffing = 1'b1;
      end
      default: begin
        bits = ~frame_crc;
        nbits = 16;
        stuffing = 1'b1;
      end
    endcase
    for (int k = 0; k < nbits; k++) begin
      if (!bits[k]) begin
        ones_run_cnt = '0;
        nrzi_level = ~nrzi_level;
      end else begin
        if (ones_run_cnt != ONES_MAX) ones_run_cnt = ones_run_cnt + 3'd1;
        if (stuffing && ones_run_cnt == ONES_STUFF) begin
          lv_q.push_back(nrzi_level);
          ones_run_cnt = '0;
          nrzi_level = ~nrzi_level;
        end
      end
      lv_q.push_back(nrzi_level);
    end
    foreach (lv_q[i]) begin
      ow.level = lv_q[i];
      ow.last = (i == lv_q.size() - 1);
      line_bits_q.push_back(ow);
    end
  endtask

  task automatic queue_word(input logic [1:0] op, input logic [7:0] data, input bit settle);
    stim_t s;
    s.w.op = op;
    s.w.data = data;
    s.settle = settle;
    pending_q.push_back(s);
  endtask

  // Bytes with long runs of ones are favored so that stuffing happens often.
  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 3))
          0: b = 8'hFF;
          1: b = 8'h1F;
          2: b = 8'hF8;
          default: b = 8'h7E;
        endcase
      end
      default: b = 8'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_cnt = 0;
    end else begin
      if (in_valid && !in_stall) begin
        serialize_word(in_word);
        accepted++;
      end
      quiet <= (pending_q.size() < CalmItems);
      if (!in_valid || !in_stall) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          gap_cnt = $urandom_range(1, 10) - 1;
          in_valid <= 1'b0;
        end else if (pending_q.size() != 0 &&
                     !(pending_q[0].settle && line_bits_q.size() != 0)) begin
          nxt = pending_q.pop_front();
          in_word <= nxt.w;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_cnt = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (line_bits_q.size() == 0) begin
          $error("line bit with none expected: level %0b last %0b",
                 out_word.level, out_word.last);
          err_cnt++;
        end else begin
          want = line_bits_q.pop_front();
          if (out_word.level !== want.level) begin
            $error("level: expected %0b, got %0b", want.level, out_word.level);
            err_cnt++;
          end
          if (out_word.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_word.last);
            err_cnt++;
          end
        end
      end
      if (stall_cnt > 0) begin
        stall_cnt--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_cnt = $urandom_range(1, 10) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int frame_no;
    frame_no = 0;

    queue_word(OP_START, 8'hA5, 1'b0);
    queue_word(OP_FLAG, 8'h7E, 1'b0);
    queue_word(OP_FLAG, 8'h7E, 1'b0);
    queue_word(OP_PAYLOAD, 8'h00, 1'b0);
    queue_word(OP_PAYLOAD, 8'hFF, 1'b0);
    queue_word(OP_PAYLOAD, 8'h1F, 1'b0);
    queue_word(OP_PAYLOAD, 8'h3E, 1'b0);
    queue_word(OP_PAYLOAD, 8'h80, 1'b0);
    queue_word(OP_PAYLOAD, 8'h01, 1'b0);
    // A second finish repeats the same check sequence.
    queue_word(OP_FCS, 8'h00, 1'b0);
    queue_word(OP_FCS, 8'hFF, 1'b0);
    queue_word(OP_FLAG, 8'h7E, 1'b0);
    // A flag full of ones saturates the run, so the payload that follows is not stuffed.
    queue_word(OP_FLAG, 8'hFF, 1'b0);
    queue_word(OP_PAYLOAD, 8'hFF, 1'b0);
    queue_word(OP_PAYLOAD, 8'h00, 1'b0);
    queue_word(OP_FLAG, 8'hFC, 1'b0);
    queue_word(OP_PAYLOAD, 8'h01, 1'b0);
    queue_word(OP_START, 8'h00, 1'b0);
    queue_word(OP_START, 8'hFF, 1'b0);
    queue_word(OP_PAYLOAD, 8'h55, 1'b0);
    queue_word(OP_PAYLOAD, 8'hAA, 1'b0);
    queue_word(OP_FCS, 8'h5A, 1'b0);
    queue_word(OP_FLAG, 8'h00, 1'b0);

    while (pending_q.size() < 200) begin
      if ($urandom_range(0, 6) == 0) begin
        queue_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 1'b0);
      end else begin
        queue_word(OP_START, 8'($urandom_range(0, 255)), (frame_no % 5) == 0);
        repeat ($urandom_range(1, 3)) queue_word(OP_FLAG, 8'h7E, 1'b0);
        repeat ($urandom_range(1, 12)) queue_word(OP_PAYLOAD, pick_byte(), 1'b0);
        queue_word(OP_FCS, 8'($urandom_range(0, 255)), 1'b0);
        repeat ($urandom_range(1, 2)) queue_word(OP_FLAG, 8'h7E, 1'b0);
        frame_no++;
      end
    end
    total = pending_q.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted < total) @(negedge clk);
    while (line_bits_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
